/* sv/qph_pkg.sv */
// qph_pkg: types and constants for the quadratic-probe hash table unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package qph_pkg;

    localparam int NUM_SLOTS     = 101;
    localparam int NUM_PROBES    = 20;
    localparam int MAX_KEY_CHARS = 15;
    localparam int CHAR_W        = 8;
    localparam int KEY_LOW_W     = 64;
    localparam int KEY_HIGH_W    = 56;
    localparam int KEY_LEN_W     = 4;
    localparam int SLOT_W        = 7;
    localparam int COUNT_W       = 7;
    localparam int PROBE_CNT_W   = 5;
    localparam int PROBE_STEP0   = 24;

    // hash arithmetic: h < 2^15, h*19 < 2^20, reciprocal of 101 rounded down
    localparam int HASH_W        = 15;
    localparam int TERM_W        = 13;
    localparam int HASH_SCALE    = 19;
    localparam int SCALED_W      = 20;
    localparam int RECIP         = 10381;
    localparam int RECIP_W       = 14;
    localparam int RECIP_SHIFT   = 20;
    localparam int PROD_W        = SCALED_W + RECIP_W;
    localparam int QUOT_W        = 13;
    localparam int REM_W         = 8;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [KEY_HIGH_W-1:0] key_high;
        logic [KEY_LEN_W-1:0]  key_length;
        logic [SLOT_W-1:0]     slot_select;
    } req_t;

    typedef struct packed {
        logic                  succeeded;
        logic [SLOT_W-1:0]     slot_index;
        logic                  slot_occupied;
        logic [COUNT_W-1:0]    entry_count;
        logic [KEY_LOW_W-1:0]  read_key_low;
        logic [KEY_HIGH_W-1:0] read_key_high;
        logic [KEY_LEN_W-1:0]  read_key_length;
    } rsp_t;

    typedef struct packed {
        logic [KEY_LOW_W-1:0]  key_low;
        logic [KEY_HIGH_W-1:0] key_high;
        logic [KEY_LEN_W-1:0]  key_length;
    } key_t;

    typedef struct packed {
        op_t               op;
        key_t              key;
        logic              key_ok;
        logic [SLOT_W-1:0] slot_select;
        logic [SLOT_W-1:0] home;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HASH,
        F_SCALE,
        F_RECIP,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_PROBE,
        B_READ,
        B_RESOLVE
    } back_state_t;

endpackage

`default_nettype wire

/* sv/quadratic_probe_hash_table_unit.sv */
// Top level: instantiates qph_front, qph_fifo, qph_back; uses qph_pkg. Results cannot be stalled.
// The front holds busy longer on a hashed add/delete than on other items, and a two-entry
// queue lets it accept the next item while the back is still probing the slot memory.
// Reset (rst_n, async low) empties the table, zeroes the count and drops queued items.
`default_nettype none

module quadratic_probe_hash_table_unit import qph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t head;
    logic empty;

    qph_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    qph_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    qph_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

/* sv/qph_front.sv */
// qph_front: accepts items, masks the key, computes the home slot.
// Depends on qph_pkg; feeds qph_fifo.
`default_nettype none

module qph_front import qph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      push,
    output job_t      push_job,
    input  wire logic full
);

    front_state_t              state_reg, state_next;
    job_t                      job_reg;
    logic [HASH_W-1:0]         hash_reg;
    logic [KEY_LEN_W-1:0]      idx_reg;
    logic [SCALED_W-1:0]       scaled_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic [REM_W-1:0]          rem_reg;

    logic [KEY_LOW_W-1:0]      lo_masked;
    logic [KEY_HIGH_W-1:0]     hi_masked;
    logic                      key_ok_in;
    logic                      need_hash;
    logic [KEY_HIGH_W+KEY_LOW_W-1:0] key_bytes;
    logic [CHAR_W-1:0]         cur_char;
    logic [KEY_LEN_W:0]        weight;
    logic [TERM_W-1:0]         term;
    logic                      last_char;
    logic [PROD_W-1:0]         recip_prod;
    logic [SLOT_W-1:0]         home;

    always_comb
    begin
        for (int b = 0; b < KEY_LOW_W / CHAR_W; b++)
        begin
            lo_masked[b*CHAR_W +: CHAR_W] = (b < int'(req.key_length)) ?
                req.key_low[b*CHAR_W +: CHAR_W] : '0;
        end
        for (int b = 0; b < KEY_HIGH_W / CHAR_W; b++)
        begin
            hi_masked[b*CHAR_W +: CHAR_W] =
                (b + KEY_LOW_W / CHAR_W < int'(req.key_length)) ?
                req.key_high[b*CHAR_W +: CHAR_W] : '0;
        end
    end

    assign key_ok_in = (req.key_length != '0) &&
                       (req.key_length <= KEY_LEN_W'(MAX_KEY_CHARS));
    assign need_hash = key_ok_in &&
                       (op_t'(req.opcode) == OP_ADD || op_t'(req.opcode) == OP_DELETE);

    assign key_bytes  = {job_reg.key.key_high, job_reg.key.key_low};
    assign cur_char   = key_bytes[{idx_reg, 3'b000} +: CHAR_W];
    assign weight     = {1'b0, idx_reg} + (KEY_LEN_W+1)'(1);
    assign term       = TERM_W'(cur_char) * TERM_W'(weight);
    assign last_char  = (idx_reg == job_reg.key.key_length - KEY_LEN_W'(1));
    assign recip_prod = PROD_W'(scaled_reg) * PROD_W'(RECIP);
    assign home       = (rem_reg >= REM_W'(NUM_SLOTS)) ?
                        SLOT_W'(rem_reg - REM_W'(NUM_SLOTS)) : SLOT_W'(rem_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = need_hash ? F_HASH : F_PUSH;
            end
            F_HASH:  state_next = last_char ? F_SCALE : F_HASH;
            F_SCALE: state_next = F_RECIP;
            F_RECIP: state_next = F_MOD;
            F_MOD:   state_next = F_PUSH;
            F_PUSH:  state_next = full ? F_PUSH : F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != F_IDLE);
        push          = (state_reg == F_PUSH) && !full;
        push_job      = job_reg;
        push_job.home = home;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    job_reg.op             <= op_t'(req.opcode);
                    job_reg.key.key_low    <= lo_masked;
                    job_reg.key.key_high   <= hi_masked;
                    job_reg.key.key_length <= req.key_length;
                    job_reg.key_ok         <= key_ok_in;
                    job_reg.slot_select    <= req.slot_select;
                    job_reg.home           <= '0;
                    hash_reg               <= '0;
                    idx_reg                <= '0;
                end
            end
            F_HASH:
            begin
                hash_reg <= hash_reg + HASH_W'(term);
                idx_reg  <= idx_reg + KEY_LEN_W'(1);
            end
            F_SCALE: scaled_reg <= SCALED_W'(hash_reg) * SCALED_W'(HASH_SCALE);
            F_RECIP: quot_reg   <= recip_prod[RECIP_SHIFT +: QUOT_W];
            F_MOD:
            begin
                rem_reg <= REM_W'(scaled_reg - SCALED_W'(quot_reg) * SCALED_W'(NUM_SLOTS));
            end
            F_PUSH: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/qph_fifo.sv */
// qph_fifo: short job queue between the front and back parts.
// Depends on qph_pkg.
`default_nettype none

module qph_fifo import qph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head,
    output logic      empty
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

/* sv/qph_back.sv */
// qph_back: slot memory, valid bits and entry count; runs the probe sequence.
// Depends on qph_pkg; takes jobs from qph_fifo.
`default_nettype none

module qph_back import qph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    input  wire job_t head,
    output logic      pop,
    output logic      done,
    output rsp_t      rsp
);

    back_state_t            state_reg, state_next;
    job_t                   cur_reg;
    key_t                   mem [NUM_SLOTS];
    key_t                   rd_data_reg;
    logic [NUM_SLOTS-1:0]   valid_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [SLOT_W-1:0]      addr_reg;
    logic [SLOT_W-1:0]      step_reg;
    logic [PROBE_CNT_W-1:0] issue_cnt_reg;
    logic                   cmp_live_reg;
    logic                   cmp_last_reg;
    logic [SLOT_W-1:0]      cmp_addr_reg;
    logic                   cmp_vld_reg;
    logic                   found_reg;
    logic [SLOT_W-1:0]      found_addr_reg;
    logic                   hole_reg;
    logic [SLOT_W-1:0]      hole_addr_reg;
    logic                   done_reg;
    rsp_t                   rsp_reg;

    logic                   sel_ok;
    logic [SLOT_W-1:0]      sel_addr;
    logic [SLOT_W-1:0]      rd_addr;
    logic [SLOT_W:0]        addr_sum;
    logic [SLOT_W-1:0]      addr_adv;
    logic                   hit;
    logic                   hole;

    logic                   start_probe;
    logic                   issue;
    logic                   emit;
    logic                   mem_we;
    logic                   set_valid;
    logic                   clr_valid;
    logic                   clear_all;
    logic [COUNT_W-1:0]     count_next;
    rsp_t                   rsp_next;

    assign sel_ok   = (cur_reg.slot_select < SLOT_W'(NUM_SLOTS));
    assign sel_addr = sel_ok ? cur_reg.slot_select : '0;
    assign rd_addr  = (state_reg == B_START) ? sel_addr : addr_reg;
    assign addr_sum = {1'b0, addr_reg} + {1'b0, step_reg};
    assign addr_adv = (addr_sum >= (SLOT_W+1)'(NUM_SLOTS)) ?
                      SLOT_W'(addr_sum - (SLOT_W+1)'(NUM_SLOTS)) : SLOT_W'(addr_sum);
    assign hit      = cmp_live_reg && cmp_vld_reg && (rd_data_reg == cur_reg.key);
    assign hole     = cmp_live_reg && !cmp_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = B_START;
            end
            B_START:
            begin
                unique case (cur_reg.op)
                    OP_ADD, OP_DELETE: state_next = cur_reg.key_ok ? B_PROBE : B_IDLE;
                    OP_READ:           state_next = B_READ;
                    OP_CLEAR:          state_next = B_IDLE;
                    default:           state_next = B_IDLE;
                endcase
            end
            B_PROBE:
            begin
                if (cmp_live_reg && cmp_last_reg)
                    state_next = B_RESOLVE;
            end
            B_READ:    state_next = B_IDLE;
            B_RESOLVE: state_next = B_IDLE;
            default:   state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        start_probe = 1'b0;
        issue       = 1'b0;
        emit        = 1'b0;
        mem_we      = 1'b0;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        clear_all   = 1'b0;
        count_next  = count_reg;
        rsp_next    = '0;
        unique case (state_reg)
            B_IDLE: pop = !empty;
            B_START:
            begin
                unique case (cur_reg.op)
                    OP_ADD, OP_DELETE:
                    begin
                        start_probe = cur_reg.key_ok;
                        emit        = !cur_reg.key_ok;
                    end
                    OP_READ: ;
                    OP_CLEAR:
                    begin
                        clear_all          = 1'b1;
                        count_next         = '0;
                        emit               = 1'b1;
                        rsp_next.succeeded = 1'b1;
                    end
                    default: ;
                endcase
            end
            B_PROBE: issue = (issue_cnt_reg < PROBE_CNT_W'(NUM_PROBES));
            B_READ:
            begin
                emit = 1'b1;
                if (sel_ok)
                begin
                    rsp_next.succeeded  = 1'b1;
                    rsp_next.slot_index = cur_reg.slot_select;
                    if (cmp_vld_reg)
                    begin
                        rsp_next.slot_occupied   = 1'b1;
                        rsp_next.read_key_low    = rd_data_reg.key_low;
                        rsp_next.read_key_high   = rd_data_reg.key_high;
                        rsp_next.read_key_length = rd_data_reg.key_length;
                    end
                end
            end
            B_RESOLVE:
            begin
                emit = 1'b1;
                if (cur_reg.op == OP_ADD)
                begin
                    if (!found_reg && hole_reg)
                    begin
                        mem_we              = 1'b1;
                        set_valid           = 1'b1;
                        count_next          = count_reg + COUNT_W'(1);
                        rsp_next.succeeded  = 1'b1;
                        rsp_next.slot_index = hole_addr_reg;
                    end
                end
                else if (found_reg)
                begin
                    clr_valid           = 1'b1;
                    count_next          = (count_reg != '0) ?
                                          count_reg - COUNT_W'(1) : count_reg;
                    rsp_next.succeeded  = 1'b1;
                    rsp_next.slot_index = found_addr_reg;
                end
            end
            default: ;
        endcase
        rsp_next.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            cmp_live_reg  <= 1'b0;
            cmp_last_reg  <= 1'b0;
            found_reg     <= 1'b0;
            hole_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= emit;
            if (clear_all)
                valid_reg <= '0;
            else
            begin
                if (set_valid)
                    valid_reg[hole_addr_reg] <= 1'b1;
                if (clr_valid)
                    valid_reg[found_addr_reg] <= 1'b0;
            end

            if (start_probe)
            begin
                issue_cnt_reg <= '0;
                cmp_live_reg  <= 1'b0;
                cmp_last_reg  <= 1'b0;
                found_reg     <= 1'b0;
                hole_reg      <= 1'b0;
            end
            else
            begin
                cmp_live_reg <= issue;
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + PROBE_CNT_W'(1);
                    cmp_last_reg  <= (issue_cnt_reg == PROBE_CNT_W'(NUM_PROBES - 1));
                end
                if (hit)
                    found_reg <= 1'b1;
                if (hole)
                    hole_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (pop)
            cur_reg <= head;
        if (start_probe)
        begin
            addr_reg <= cur_reg.home;
            step_reg <= SLOT_W'(PROBE_STEP0);
        end
        else if (issue)
        begin
            addr_reg <= addr_adv;
            step_reg <= step_reg + SLOT_W'(2);
        end
        if (state_reg == B_START)
            cmp_vld_reg <= sel_ok && valid_reg[sel_addr];
        else if (issue)
            cmp_vld_reg <= valid_reg[addr_reg];
        if (issue)
            cmp_addr_reg <= addr_reg;
        if (hit && !found_reg)
            found_addr_reg <= cmp_addr_reg;
        if (hole && !hole_reg)
            hole_addr_reg <= cmp_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[hole_addr_reg] <= cur_reg.key;
        rd_data_reg <= mem[rd_addr];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

/* sv/qph_checker.sv */
// qph_checker: port-level assertions for the hash table unit, bound to the top level.
// Depends on qph_pkg and quadratic_probe_hash_table_unit.
`default_nettype none

module qph_checker import qph_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on adjacent cycles");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.succeeded |-> rsp.slot_index == '0 && !rsp.slot_occupied)
        else $error("failed item reports a slot");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.slot_occupied |->
            rsp.read_key_low == '0 && rsp.read_key_high == '0 &&
            rsp.read_key_length == '0)
        else $error("key data without an occupied slot");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.entry_count <= COUNT_W'(NUM_SLOTS) &&
            (!rsp.slot_occupied || rsp.read_key_length != '0))
        else $error("entry count or stored key length out of range");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for quadratic_probe_hash_table_unit (add/delete/read/clear).
// A scoreboard class mirrors the 101-slot table and checks every result in order.
// Depends on qph_pkg and the RTL of the block only.

module tb;
    import qph_pkg::*;

    localparam int PROBE_STRIDE   = 23;
    localparam int MAX_GAP        = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 48;
    localparam int ROUNDS         = 6;
    localparam int ROUND_ITEMS    = 110;
    localparam int KNOWN_CAP      = 256;
    localparam int PRINT_CAP      = 100;

    class table_scoreboard;
        key_t slot_key [NUM_SLOTS];
        bit   slot_used [NUM_SLOTS];
        int   stored;
        rsp_t expected_q [$];
        int   mismatches;

        function new();
            foreach (slot_used[s])
                slot_used[s] = 1'b0;
            stored = 0;
            mismatches = 0;
        endfunction

        // drop character bytes beyond the key length
        function key_t canon(logic [KEY_LOW_W-1:0] lo, logic [KEY_HIGH_W-1:0] hi,
                             logic [KEY_LEN_W-1:0] len);
            key_t k;
            k = '0;
            k.key_length = len;
            for (int i = 0; i < 8; i++)
                if (i < len)
                    k.key_low[8*i +: 8] = lo[8*i +: 8];
            for (int i = 0; i < 7; i++)
                if (i + 8 < len)
                    k.key_high[8*i +: 8] = hi[8*i +: 8];
            return k;
        endfunction

        function int home_of(key_t k);
            int h;
            int c;
            h = 0;
            for (int i = 0; i < MAX_KEY_CHARS; i++)
            begin
                if (i < k.key_length)
                begin
                    if (i < 8)
                        c = k.key_low[8*i +: 8];
                    else
                        c = k.key_high[8*(i-8) +: 8];
                    h += c * (i + 1);
                end
            end
            return (h * HASH_SCALE) % NUM_SLOTS;
        endfunction

        function int probe_at(int home, int j);
            return (home + PROBE_STRIDE * j + j * j) % NUM_SLOTS;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        function void note_item(req_t r);
            rsp_t e;
            key_t k;
            int   home;
            int   s;
            bit   dup;
            e = '0;
            k = canon(r.key_low, r.key_high, r.key_length);
            case (r.opcode)
                OP_ADD:
                begin
                    if (k.key_length != 0)
                    begin
                        home = home_of(k);
                        dup = 1'b0;
                        for (int j = 0; j < NUM_PROBES; j++)
                        begin
                            s = probe_at(home, j);
                            if (slot_used[s] && slot_key[s] == k)
                                dup = 1'b1;
                        end
                        if (!dup)
                        begin
                            for (int j = 0; j < NUM_PROBES; j++)
                            begin
                                s = probe_at(home, j);
                                if (!slot_used[s])
                                begin
                                    slot_used[s] = 1'b1;
                                    slot_key[s] = k;
                                    stored++;
                                    e.succeeded = 1'b1;
                                    e.slot_index = s[SLOT_W-1:0];
                                    break;
                                end
                            end
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (k.key_length != 0)
                    begin
                        for (s = 0; s < NUM_SLOTS; s++)
                        begin
                            if (slot_used[s] && slot_key[s] == k)
                            begin
                                slot_used[s] = 1'b0;
                                stored--;
                                e.succeeded = 1'b1;
                                e.slot_index = s[SLOT_W-1:0];
                                break;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (r.slot_select < NUM_SLOTS)
                    begin
                        e.succeeded = 1'b1;
                        e.slot_index = r.slot_select;
                        if (slot_used[r.slot_select])
                        begin
                            e.slot_occupied = 1'b1;
                            e.read_key_low = slot_key[r.slot_select].key_low;
                            e.read_key_high = slot_key[r.slot_select].key_high;
                            e.read_key_length = slot_key[r.slot_select].key_length;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    foreach (slot_used[i])
                        slot_used[i] = 1'b0;
                    stored = 0;
                    e.succeeded = 1'b1;
                end
            endcase
            e.entry_count = stored[COUNT_W-1:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t  e;
            string diffs;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no item pending: %h", got));
                return;
            end
            e = expected_q.pop_front();
            diffs = "";
            if (got.succeeded !== e.succeeded)
                diffs = {diffs, $sformatf(" succeeded %0h/%0h", got.succeeded, e.succeeded)};
            if (got.slot_index !== e.slot_index)
                diffs = {diffs, $sformatf(" slot_index %0d/%0d", got.slot_index, e.slot_index)};
            if (got.slot_occupied !== e.slot_occupied)
                diffs = {diffs, $sformatf(" slot_occupied %0h/%0h",
                                          got.slot_occupied, e.slot_occupied)};
            if (got.entry_count !== e.entry_count)
                diffs = {diffs, $sformatf(" entry_count %0d/%0d", got.entry_count, e.entry_count)};
            if (got.read_key_low !== e.read_key_low)
                diffs = {diffs, $sformatf(" read_key_low %h/%h", got.read_key_low, e.read_key_low)};
            if (got.read_key_high !== e.read_key_high)
                diffs = {diffs, $sformatf(" read_key_high %h/%h",
                                          got.read_key_high, e.read_key_high)};
            if (got.read_key_length !== e.read_key_length)
                diffs = {diffs, $sformatf(" read_key_length %0d/%0d",
                                          got.read_key_length, e.read_key_length)};
            if (diffs != "")
                report({"result (got/exp):", diffs});
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    table_scoreboard sb = new();
    key_t known_keys [$];
    bit   no_idle = 1'b0;
    int   family_h = 200;
    int   idle_cycles = 0;

    quadratic_probe_hash_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_result(rsp);
            if (start && busy === 1'b0)
                sb.note_item(req);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_t mk(op_t op, key_t k, int sel);
        req_t r;
        r.opcode = op;
        r.key_low = k.key_low;
        r.key_high = k.key_high;
        r.key_length = k.key_length;
        r.slot_select = sel[SLOT_W-1:0];
        return r;
    endfunction

    function automatic key_t random_key();
        key_t        k;
        logic [63:0] hi_bits;
        k.key_low = {$urandom, $urandom};
        hi_bits = {$urandom, $urandom};
        k.key_high = hi_bits[KEY_HIGH_W-1:0];
        k.key_length = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, MAX_KEY_CHARS));
        return k;
    endfunction

    // same characters, fresh junk above the key length
    function automatic key_t dirty(key_t k);
        key_t m;
        key_t n;
        m = sb.canon('1, '1, k.key_length);
        n = random_key();
        n.key_low = (n.key_low & ~m.key_low) | k.key_low;
        n.key_high = (n.key_high & ~m.key_high) | k.key_high;
        n.key_length = k.key_length;
        return n;
    endfunction

    // two-character key with c0 + 2*c1 == h, so every one shares a home slot
    function automatic key_t family_key(int h, int c1);
        key_t k;
        k = random_key();
        k.key_low[15:0] = {8'(c1), 8'(h - 2 * c1)};
        k.key_length = 4'd2;
        return k;
    endfunction

    function automatic int family_c1(int h);
        int lo_c1;
        int hi_c1;
        lo_c1 = (h > 255) ? (h - 254) / 2 : 0;
        hi_c1 = h / 2;
        return $urandom_range(lo_c1, hi_c1);
    endfunction

    function automatic void note_known(key_t k);
        if (k.key_length == 0)
            return;
        known_keys.push_back(sb.canon(k.key_low, k.key_high, k.key_length));
        if (known_keys.size() > KNOWN_CAP)
            void'(known_keys.pop_front());
    endfunction

    task automatic send(req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_item(bit filling);
        int   roll;
        int   sub;
        key_t k;
        roll = $urandom_range(0, 999);
        if (roll < 4)
        begin
            send(mk(OP_CLEAR, random_key(), $urandom_range(0, 127)));
        end
        else if (roll < (filling ? 560 : 160))
        begin
            sub = $urandom_range(0, 9);
            if (sub < 2 && known_keys.size() > 0)
                k = dirty(known_keys[$urandom_range(0, known_keys.size() - 1)]);
            else if (sub < 4)
                k = family_key(family_h, family_c1(family_h));
            else
                k = random_key();
            note_known(k);
            send(mk(OP_ADD, k, $urandom_range(0, 127)));
        end
        else if (roll < (filling ? 780 : 720))
        begin
            if ($urandom_range(0, 99) < 85 && known_keys.size() > 0)
                k = dirty(known_keys[$urandom_range(0, known_keys.size() - 1)]);
            else
                k = random_key();
            send(mk(OP_DELETE, k, $urandom_range(0, 127)));
        end
        else
        begin
            send(mk(OP_READ, random_key(),
                    ($urandom_range(0, 99) < 85) ? $urandom_range(0, NUM_SLOTS - 1)
                                                 : $urandom_range(NUM_SLOTS, 127)));
        end
    endtask

    initial
    begin
        key_t key_a;
        key_t key_ones;
        key_t key_zero;
        int   c1_base;

        key_a = key_t'{64'h41, 56'h0, 4'd1};
        key_ones = key_t'{'1, '1, 4'd15};
        key_zero = key_t'{'0, '0, 4'd15};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: bounds, empty key, duplicates, missing key, clear
        send(mk(OP_READ, key_a, 0));
        send(mk(OP_READ, key_a, NUM_SLOTS - 1));
        send(mk(OP_READ, key_a, NUM_SLOTS));
        send(mk(OP_READ, key_a, 127));
        send(mk(OP_ADD, key_t'{'1, '1, 4'd0}, 0));
        send(mk(OP_DELETE, key_t'{'1, '1, 4'd0}, 0));
        send(mk(OP_ADD, key_a, 0));
        send(mk(OP_ADD, key_t'{64'hFFFF_FFFF_FFFF_FF41, '1, 4'd1}, 127));
        send(mk(OP_ADD, key_ones, 0));
        send(mk(OP_ADD, key_zero, 0));
        send(mk(OP_ADD, key_t'{64'h0123_4567_89AB_CDEF, '1, 4'd8}, 0));
        send(mk(OP_ADD, key_t'{64'h8000_0000_0000_0001, 56'h80_0000_0000_00A5, 4'd9}, 0));
        send(mk(OP_DELETE, key_t'{64'h42, 56'h0, 4'd1}, 0));
        send(mk(OP_READ, key_a, sb.home_of(key_a)));
        send(mk(OP_DELETE, key_a, 0));
        send(mk(OP_DELETE, key_a, 0));
        send(mk(OP_READ, key_ones, sb.home_of(key_ones)));
        send(mk(OP_CLEAR, key_ones, 0));
        send(mk(OP_READ, key_ones, sb.home_of(key_ones)));
        send(mk(OP_ADD, key_ones, 0));
        send(mk(OP_DELETE, key_ones, 0));
        wait_drained();

        // one home slot hammered past its 20 probes: last adds hit a full path
        family_h = $urandom_range(200, 300);
        c1_base = ((family_h > 255) ? (family_h - 254) / 2 : 0) + 1 + $urandom_range(0, 50);
        send(mk(OP_CLEAR, random_key(), 0));
        for (int n = 0; n < 22; n++)
        begin
            key_a = family_key(family_h, c1_base + n);
            note_known(key_a);
            send(mk(OP_ADD, key_a, 0));
        end

        for (int round = 0; round < ROUNDS; round++)
        begin
            family_h = $urandom_range(60, 300);
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                random_item(round % 2 == 0);
            end
            if (round == 3)
                send(mk(OP_CLEAR, random_key(), $urandom_range(0, 127)));
            if ($urandom_range(0, 1) == 1)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
